FILE: rtl/ahcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahcu_pkg
// Shared types, constants and the CRC-32 byte update for the archive header
// check and payload unrotate block.
// ----------------------------------------------------------------------------
package ahcu_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Header layout (byte positions)
  localparam logic [4:0] POS_MAGIC_END = 5'd3;   // magic occupies 0..2
  localparam logic [4:0] POS_OFF_LO    = 5'd6;
  localparam logic [4:0] POS_OFF_HI    = 5'd9;
  localparam logic [4:0] POS_CNT_LO    = 5'd10;
  localparam logic [4:0] POS_CNT_HI    = 5'd13;
  localparam logic [4:0] POS_CRC_LO    = 5'd14;
  localparam logic [4:0] POS_LAST      = 5'd17;
  localparam logic [4:0] POS_PAST      = 5'd18;  // past the header

  localparam logic [31:0] HEADER_LEN = 32'd18;

  // Magic bytes, byte 0 in the low lane
  localparam logic [23:0] MAGIC_WORD = 24'h46_43_54;

  // Queue between front and back
  localparam int Q_AW    = 1;
  localparam int Q_DEPTH = 2;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_PAYLOAD = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    ST_OK               = 2'd0,
    ST_BAD_MAGIC        = 2'd1,
    ST_CRC_MISMATCH     = 2'd2,
    ST_OFFSET_IN_HEADER = 2'd3
  } status_t;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_TAIL   = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [4:0] pos;
    logic [7:0] data;
  } beat_op_t;

  // Reflected CRC-32, one byte, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/ahcu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahcu_front
// Input side: takes beats, tracks the header position and tags each byte
// as a header byte or a byte after the header; drops bytes before a start.
// ----------------------------------------------------------------------------
module ahcu_front
  import ahcu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_archive,
  input  logic       q_full,
  output logic       push,
  output beat_op_t   push_op
);

  logic       armed_r, armed_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic       accept;

  always_comb begin
    in_ready     = !q_full;
    accept       = in_valid && in_ready;
    armed_nxt    = armed_r;
    pos_nxt      = pos_r;
    push         = 1'b0;
    push_op.kind = OP_HEADER;
    push_op.pos  = pos_r;
    push_op.data = in_data_byte;
    if (in_first_of_archive) begin
      push_op.pos = 5'd0;
      push        = accept;
      if (accept) begin
        armed_nxt = 1'b1;
        pos_nxt   = 5'd1;
      end
    end else if (armed_r && pos_r != POS_PAST) begin
      push = accept;
      if (accept) pos_nxt = pos_r + 5'd1;
    end else if (armed_r) begin
      push_op.kind = OP_TAIL;
      push         = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      pos_r   <= 5'd0;
    end else begin
      armed_r <= armed_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

FILE: rtl/ahcu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahcu_fifo
// Two-entry queue of tagged bytes between the front and the back.
// ----------------------------------------------------------------------------
module ahcu_fifo
  import ahcu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  beat_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output beat_op_t q_op
);

  beat_op_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     count_r, count_nxt;

  always_comb begin
    full       = (count_r == Q_DEPTH[Q_AW:0]);
    q_valid    = (count_r != '0);
    q_op       = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_DEPTH[Q_AW:0])
    else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule

FILE: rtl/ahcu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahcu_back
// Execution side: CRC and field capture over the header, verdict, payload
// countdown and unrotate, result register toward the output channel.
// ----------------------------------------------------------------------------
module ahcu_back
  import ahcu_pkg::*;
#(
  parameter int ROTATE_BITS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  beat_op_t    q_op,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_idx_offset,
  output logic [31:0] out_file_count,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_payload
);

  logic [31:0] crc_r, crc_nxt;
  logic        magic_r, magic_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] count_r, count_nxt;
  logic [23:0] stored_r, stored_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic        active_r, active_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] ooff_r, ooff_nxt;
  logic [31:0] ocnt_r, ocnt_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        olast_r, olast_nxt;

  logic [4:0]  p;
  logic [4:0]  d_off, d_cnt, d_crc;
  logic [31:0] crc_base, off_base, cnt_base;
  logic [23:0] st_base;
  logic        mg_base;
  logic [31:0] stored_full;
  logic [31:0] rem_dec;
  logic [15:0] dbl;
  status_t     verdict;
  logic        emit;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    p           = q_op.pos;
    d_off       = p - POS_OFF_LO;
    d_cnt       = p - POS_CNT_LO;
    d_crc       = p - POS_CRC_LO;
    dbl         = {q_op.data, q_op.data};
    rem_dec     = remain_r - 32'd1;
    stored_full = {q_op.data, stored_r};

    // position 0 restarts the header state
    crc_base = (p == 5'd0) ? CRC_INIT : crc_r;
    mg_base  = (p == 5'd0) ? 1'b1     : magic_r;
    off_base = (p == 5'd0) ? '0       : offset_r;
    cnt_base = (p == 5'd0) ? '0       : count_r;
    st_base  = (p == 5'd0) ? '0       : stored_r;

    if (!magic_r)                        verdict = ST_BAD_MAGIC;
    else if (~crc_r != stored_full)      verdict = ST_CRC_MISMATCH;
    else if (offset_r < HEADER_LEN)      verdict = ST_OFFSET_IN_HEADER;
    else                                 verdict = ST_OK;

    crc_nxt    = crc_r;
    magic_nxt  = magic_r;
    offset_nxt = offset_r;
    count_nxt  = count_r;
    stored_nxt = stored_r;
    remain_nxt = remain_r;
    active_nxt = active_r;

    emit       = 1'b0;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    ooff_nxt   = ooff_r;
    ocnt_nxt   = ocnt_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;

    if (q_pop) begin
      case (q_op.kind)
        OP_HEADER: begin
          crc_nxt    = crc_base;
          magic_nxt  = mg_base;
          offset_nxt = off_base;
          count_nxt  = cnt_base;
          stored_nxt = st_base;
          if (p == 5'd0) active_nxt = 1'b0;
          if (p < POS_MAGIC_END && q_op.data != MAGIC_WORD[8*p[1:0] +: 8]) begin
            magic_nxt = 1'b0;
          end
          if (p <= POS_CNT_HI) crc_nxt = crc_byte(crc_base, q_op.data);
          if (p >= POS_OFF_LO && p <= POS_OFF_HI) begin
            offset_nxt[8*d_off[1:0] +: 8] = q_op.data;
          end else if (p >= POS_CNT_LO && p <= POS_CNT_HI) begin
            count_nxt[8*d_cnt[1:0] +: 8] = q_op.data;
          end else if (p >= POS_CRC_LO && p < POS_LAST) begin
            stored_nxt[8*d_crc[1:0] +: 8] = q_op.data;
          end
          if (p == POS_LAST) begin
            emit       = 1'b1;
            kind_nxt   = KIND_VERDICT;
            status_nxt = verdict;
            ooff_nxt   = offset_r;
            ocnt_nxt   = count_r;
            obyte_nxt  = '0;
            olast_nxt  = 1'b0;
            if (verdict == ST_OK && offset_r > HEADER_LEN) begin
              active_nxt = 1'b1;
              remain_nxt = offset_r - HEADER_LEN;
            end else begin
              active_nxt = 1'b0;
              remain_nxt = '0;
            end
          end
        end
        OP_TAIL: begin
          if (active_r) begin
            emit       = 1'b1;
            kind_nxt   = KIND_PAYLOAD;
            status_nxt = ST_OK;
            ooff_nxt   = '0;
            ocnt_nxt   = '0;
            obyte_nxt  = dbl[ROTATE_BITS +: 8];
            olast_nxt  = (rem_dec == '0);
            remain_nxt = rem_dec;
            active_nxt = (rem_dec != '0);
          end
        end
        default: ;
      endcase
    end

    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      remain_r    <= '0;
      crc_r       <= CRC_INIT;
      magic_r     <= 1'b1;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      remain_r    <= remain_nxt;
      crc_r       <= crc_nxt;
      magic_r     <= magic_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
    count_r  <= count_nxt;
    stored_r <= stored_nxt;
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    ooff_r   <= ooff_nxt;
    ocnt_r   <= ocnt_nxt;
    obyte_r  <= obyte_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_status          = status_r;
  assign out_idx_offset      = ooff_r;
  assign out_file_count      = ocnt_r;
  assign out_payload_byte    = obyte_r;
  assign out_last_of_payload = olast_r;

endmodule

FILE: rtl/archive_header_check_unrotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_header_check_unrotate
// Checks an 18-byte archive header (magic, CRC-32 over bytes 0..13, index
// offset) and emits the payload bytes rotated right.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one archive byte per beat; in_first_of_archive marks header
//           byte 0 and restarts parsing at any time, dropping an archive
//           in progress. Bytes before the first start are discarded.
//   out_* : result beats. result_kind 0 is the header verdict (status,
//           index offset, file count), sent after header byte 17.
//           result_kind 1 is a payload byte; last_of_payload marks the
//           final one (index offset minus 18 payload bytes follow an ok verdict).
//   Path: a taken byte is written into the queue; the back stage then moves
//   its result into the output register, which drives out_*. A byte can
//   wait in the queue while the output stalls.
//   Throughput: one byte per cycle while out_ready stays high; the CRC step is
//   an unrolled eight-bit update inside the back stage.
//   Stall: the back stage holds while out_valid is high and out_ready is
//   low; the two-entry queue then fills and in_ready drops once it is full.
//   Reset (rst_n low, synchronous) empties the queue and the output
//   register; the block then waits for the next start flag.
// ----------------------------------------------------------------------------
module archive_header_check_unrotate
  import ahcu_pkg::*;
#(
  parameter int ROTATE_BITS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_archive,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_idx_offset,
  output logic [31:0] out_file_count,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_payload
);

  logic     push, full, pop, q_valid;
  beat_op_t push_op, q_op;

  // Front: tag each accepted byte with its header position
  ahcu_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_first_of_archive (in_first_of_archive),
    .q_full              (full),
    .push                (push),
    .push_op             (push_op)
  );

  // Queue decouples input acceptance from output stalls
  ahcu_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  // Back: CRC, field capture, verdict, payload countdown and unrotate
  ahcu_back #(
    .ROTATE_BITS (ROTATE_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_op                (q_op),
    .q_pop               (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_status          (out_status),
    .out_idx_offset      (out_idx_offset),
    .out_file_count      (out_file_count),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_payload (out_last_of_payload)
  );

endmodule

FILE: bench/tb_archive_header_check_unrotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_archive_header_check_unrotate
// Self-checking bench for the archive header check and payload unrotate block.
// Drives byte streams of archives: an 18-byte header (some cut short) with a
// built-in CRC, then payload bytes and trailing bytes. A directed plan covers
// the verdict codes and restart cases, and random archives follow. Result beats
// are checked against a cycle-free model of the parser; the directed plan types
// in its full-header verdicts. Both sides idle at random in bursts.
// ----------------------------------------------------------------------------
module tb_archive_header_check_unrotate
  import ahcu_pkg::*;
();

  localparam int          ROT_BITS     = 2;
  localparam int          QUIET_LIMIT  = 500;   // cycles with no beat on either side
  localparam int          RANDOM_BYTES = 450;   // parsed bytes in the random part
  localparam int          CALM_TAIL    = 120;   // final stretch with no idling
  localparam logic [31:0] CRC_SEED     = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_REFL     = 32'hEDB8_8320;
  localparam logic [23:0] ARC_MAGIC    = 24'h46_43_54;  // byte 0 in low lane
  localparam int          HDR_BYTES    = 18;
  localparam int          CRC_BYTES    = 14;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } parse_phase_t;

  typedef struct packed {
    result_kind_t kind;
    status_t      status;
    logic [31:0]  offset;
    logic [31:0]  count;
    logic [7:0]   pbyte;
    logic         last;
  } arc_result_t;

  // One directed archive: junk bytes before it, header faults, fields,
  // header bytes actually sent, bytes sent after the header, typed verdict.
  typedef struct packed {
    int          junk;
    bit          mbad;
    bit          cbad;
    logic [31:0] off;
    logic [31:0] cnt;
    int          hlen;
    int          trail;
    status_t     st;
  } plan_row_t;

  localparam int PLAN_ROWS = 12;

  plan_row_t plan [PLAN_ROWS] = '{
    '{3, 1'b0, 1'b0, 32'd21,          32'd0,           18, 5, ST_OK},
    '{0, 1'b0, 1'b0, 32'd18,          32'hFFFF_FFFF,   18, 2, ST_OK},
    '{0, 1'b1, 1'b0, 32'd20,          32'd1,           18, 3, ST_BAD_MAGIC},
    '{0, 1'b1, 1'b1, 32'd5,           32'd2,           18, 1, ST_BAD_MAGIC},
    '{0, 1'b0, 1'b1, 32'd0,           32'd3,           18, 1, ST_CRC_MISMATCH},
    '{0, 1'b0, 1'b1, 32'd25,          32'd4,           18, 2, ST_CRC_MISMATCH},
    '{0, 1'b0, 1'b0, 32'd17,          32'd5,           18, 1, ST_OFFSET_IN_HEADER},
    '{0, 1'b0, 1'b0, 32'd0,           32'd6,           18, 0, ST_OFFSET_IN_HEADER},
    '{0, 1'b0, 1'b0, 32'd30,          32'd7,            9, 0, ST_OK},
    '{0, 1'b0, 1'b0, 32'hFFFF_FFFF,   32'd0,           18, 4, ST_OK},
    '{0, 1'b0, 1'b0, 32'd19,          32'h8000_0000,   18, 1, ST_OK},
    '{0, 1'b0, 1'b0, 32'd22,          32'd0,           18, 4, ST_OK}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_first_of_archive;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [1:0]  out_status;
  logic [31:0] out_idx_offset;
  logic [31:0] out_file_count;
  logic [7:0]  out_payload_byte;
  logic        out_last_of_payload;

  archive_header_check_unrotate #(.ROTATE_BITS(ROT_BITS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_first_of_archive (in_first_of_archive),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_status          (out_status),
    .out_idx_offset      (out_idx_offset),
    .out_file_count      (out_file_count),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_payload (out_last_of_payload)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser state kept by the bench
  parse_phase_t ph;
  logic [4:0]   hpos;
  logic [31:0]  crc_acc;
  logic         magic_seen_ok;
  logic [31:0]  off_acc;
  logic [31:0]  cnt_acc;
  logic [31:0]  crc_stored;
  logic [31:0]  bytes_left;

  arc_result_t awaited_results [$];
  logic [7:0]  hdr [HDR_BYTES];

  bit          idle_on;
  bit          typed_on;
  arc_result_t typed_verdict;
  int          parsed_bytes;
  int          mismatches;
  int          payload_checked;
  int          verdicts_seen [4];

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] s;
    s = c;
    for (int k = 0; k < 8; k++) begin
      if (s[0] ^ b[k]) s = (s >> 1) ^ CRC_REFL;
      else s = s >> 1;
    end
    return s;
  endfunction

  // Advances the bench's parser by one byte; returns 1 when the byte yields
  // a result beat.
  function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                    output arc_result_t r);
    int      p;
    status_t st;
    r = '0;
    if (first) begin
      ph            = PH_HEADER;
      hpos          = '0;
      crc_acc       = CRC_SEED;
      magic_seen_ok = 1'b1;
      off_acc       = '0;
      cnt_acc       = '0;
      crc_stored    = '0;
      bytes_left    = '0;
    end
    if (ph == PH_HEADER) begin
      parsed_bytes++;
      p = int'(hpos);
      if (p < 3 && b != ARC_MAGIC[8*p +: 8]) magic_seen_ok = 1'b0;
      if (p < CRC_BYTES) crc_acc = crc_step(crc_acc, b);
      if (p >= 6 && p <= 9) off_acc[8*(p-6) +: 8] = b;
      else if (p >= 10 && p <= 13) cnt_acc[8*(p-10) +: 8] = b;
      else if (p >= 14) crc_stored[8*(p-14) +: 8] = b;
      if (p < HDR_BYTES - 1) begin
        hpos = hpos + 5'd1;
        return 1'b0;
      end
      // Fault priority: magic, then CRC, then an offset inside the header
      if (!magic_seen_ok) st = ST_BAD_MAGIC;
      else if (~crc_acc != crc_stored) st = ST_CRC_MISMATCH;
      else if (off_acc < HDR_BYTES) st = ST_OFFSET_IN_HEADER;
      else st = ST_OK;
      if (st == ST_OK && off_acc > HDR_BYTES) begin
        bytes_left = off_acc - HDR_BYTES;
        ph = PH_PAYLOAD;
      end else begin
        bytes_left = '0;
        ph = PH_DONE;
      end
      r.kind   = KIND_VERDICT;
      r.status = st;
      r.offset = off_acc;
      r.count  = cnt_acc;
      return 1'b1;
    end
    if (ph == PH_PAYLOAD) begin
      parsed_bytes++;
      bytes_left = bytes_left - 32'd1;
      r.kind   = KIND_PAYLOAD;
      r.status = ST_OK;
      r.pbyte  = 8'({b, b} >> ROT_BITS);
      if (bytes_left == 0) begin
        r.last = 1'b1;
        ph = PH_DONE;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Fills hdr with a header carrying the given fields and a matching CRC,
  // then breaks the magic or the CRC on request.
  function automatic void build_header(input bit mbad, input bit cbad,
                                       input logic [31:0] off, input logic [31:0] cnt);
    logic [31:0] c;
    int          k;
    for (k = 0; k < HDR_BYTES; k++) hdr[k] = 8'($urandom);
    for (k = 0; k < 3; k++) hdr[k] = ARC_MAGIC[8*k +: 8];
    if (mbad) begin
      k = $urandom_range(0, 2);
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k < 4; k++) begin
      hdr[6+k]  = off[8*k +: 8];
      hdr[10+k] = cnt[8*k +: 8];
    end
    c = CRC_SEED;
    for (k = 0; k < CRC_BYTES; k++) c = crc_step(c, hdr[k]);
    c = ~c;
    if (cbad) c = c ^ (32'd1 << $urandom_range(0, 31));
    for (k = 0; k < 4; k++) hdr[14+k] = c[8*k +: 8];
  endfunction

  // Holds one byte on the input channel until it is taken, then records
  // the result it should cause.
  task automatic send_byte(input logic [7:0] b, input logic first);
    arc_result_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data_byte        <= b;
    in_first_of_archive <= first;
    do @(posedge clk); while (!in_ready);
    if (parse_byte(b, first, r)) begin
      if (typed_on && r.kind == KIND_VERDICT) r = typed_verdict;
      awaited_results.push_back(r);
    end
  endtask

  task automatic send_archive(input int junk, input bit mbad, input bit cbad,
                              input logic [31:0] off, input logic [31:0] cnt,
                              input int hlen, input int trail);
    repeat (junk) send_byte(8'($urandom), 1'b0);
    build_header(mbad, cbad, off, cnt);
    for (int k = 0; k < hlen; k++) send_byte(hdr[k], k == 0);
    // payload bytes and whatever follows them; the parser decides which is which
    repeat (trail) send_byte(8'($urandom), 1'b0);
  endtask

  // Result side: random stall bursts, every taken beat checked in order.
  int          stall_left;
  arc_result_t want;
  arc_result_t got;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind   = result_kind_t'(out_result_kind);
        got.status = status_t'(out_status);
        got.offset = out_idx_offset;
        got.count  = out_file_count;
        got.pbyte  = out_payload_byte;
        got.last   = out_last_of_payload;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat kind %0d status %0d off %h cnt %h byte %h last %0d",
                     $realtime, got.kind, got.status, got.offset, got.count, got.pbyte,
                     got.last);
        end else begin
          want = awaited_results.pop_front();
          if (want.kind === KIND_VERDICT) verdicts_seen[want.status]++;
          else payload_checked++;
          if (got.kind !== want.kind || got.status !== want.status ||
              got.offset !== want.offset || got.count !== want.count ||
              got.pbyte !== want.pbyte || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp/act kind %0d/%0d status %0d/%0d off %h/%h",
                       $realtime, want.kind, got.kind, want.status, got.status,
                       want.offset, got.offset);
              $display("  cnt %h/%h byte %h/%h last %0d/%0d",
                       want.count, got.count, want.pbyte, got.pbyte, want.last, got.last);
            end
          end
        end
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  int quiet;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, awaited_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int          goal;
    int          sel;
    int          trail;
    bit          mbad;
    bit          cbad;
    logic [31:0] off;
    logic [31:0] cnt;
    int          hlen;
    plan_row_t   row;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_data_byte        = 8'h00;
    in_first_of_archive = 1'b0;
    idle_on             = 1'b1;
    typed_on            = 1'b0;
    typed_verdict       = '0;
    parsed_bytes        = 0;
    mismatches          = 0;
    payload_checked     = 0;
    quiet               = 0;
    stall_left          = 0;
    for (int s = 0; s < 4; s++) verdicts_seen[s] = 0;
    ph            = PH_IDLE;
    hpos          = '0;
    crc_acc       = CRC_SEED;
    magic_seen_ok = 1'b1;
    off_acc       = '0;
    cnt_acc       = '0;
    crc_stored    = '0;
    bytes_left    = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan: verdicts are typed in, payload beats come from the parser
    for (int i = 0; i < PLAN_ROWS; i++) begin
      row                  = plan[i];
      typed_on             = (row.hlen == HDR_BYTES);
      typed_verdict        = '0;
      typed_verdict.kind   = KIND_VERDICT;
      typed_verdict.status = row.st;
      typed_verdict.offset = row.off;
      typed_verdict.count  = row.cnt;
      send_archive(row.junk, row.mbad, row.cbad, row.off, row.cnt, row.hlen, row.trail);
    end
    typed_on = 1'b0;

    // Random archives, mostly well formed; faults, short headers, huge
    // offsets and stray bytes mixed in.
    goal = parsed_bytes + RANDOM_BYTES;
    while (parsed_bytes < goal) begin
      if (parsed_bytes > goal - CALM_TAIL) idle_on = 1'b0;
      sel  = $urandom_range(0, 99);
      mbad = (sel < 8) || (sel == 99);
      cbad = (sel >= 8 && sel < 16) || (sel >= 97);
      if (sel >= 16 && sel < 24) off = $urandom_range(0, 17);
      else if (sel >= 24 && sel < 30) off = $urandom;
      else off = 32'd18 + $urandom_range(0, 12);
      case ($urandom_range(0, 9))
        0:       cnt = 32'd0;
        1:       cnt = 32'hFFFF_FFFF;
        default: cnt = $urandom;
      endcase
      hlen = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 17) : HDR_BYTES;
      if (off >= 18 && off <= 30) begin
        trail = int'(off) - 18;
        if ($urandom_range(0, 3) == 0) trail += $urandom_range(1, 3);
        if ($urandom_range(0, 9) == 0) trail = $urandom_range(0, trail);
      end else begin
        trail = $urandom_range(0, 6);
      end
      send_archive(($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                   mbad, cbad, off, cnt, hlen, trail);
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // Let any stray extra beat show up before the verdict
    repeat (10) @(posedge clk);

    $display("parsed %0d header and payload bytes; %0d payload beats checked",
             parsed_bytes, payload_checked);
    $display("verdicts: ok %0d, bad magic %0d, crc mismatch %0d, offset in header %0d",
             verdicts_seen[ST_OK], verdicts_seen[ST_BAD_MAGIC],
             verdicts_seen[ST_CRC_MISMATCH], verdicts_seen[ST_OFFSET_IN_HEADER]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ahcu_pkg.sv
rtl/ahcu_front.sv
rtl/ahcu_fifo.sv
rtl/ahcu_back.sv
rtl/archive_header_check_unrotate.sv
bench/tb_archive_header_check_unrotate.sv
